@@ hdl/crc16_packet_deframer_macros.svh @@
// Assertion macros for the deframer. Each expects clk and rst in scope.
`ifndef CRC16_PACKET_DEFRAMER_MACROS_SVH
`define CRC16_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define CRCDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define CRCDF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define CRCDF_ASSERT_IMP(label, ante, cons)
`define CRCDF_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ hdl/crcdf_pkg.sv @@
`timescale 1ns / 1ps

package crcdf_pkg;

  localparam logic [7:0]  START_SHORT = 8'h02;
  localparam logic [7:0]  START_LONG  = 8'h03;
  localparam logic [7:0]  STOP_MARK   = 8'h03;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEN_SHORT = 3'd1,
    PH_LEN_HI    = 3'd2,
    PH_LEN_LO    = 3'd3,
    PH_PAYLOAD   = 3'd4,
    PH_CRC_HI    = 3'd5,
    PH_CRC_LO    = 3'd6,
    PH_STOP      = 3'd7
  } phase_t;

  // One received item as held in the input register.
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } step_t;

  // Result of one step, valid marks that the step gives an item.
  typedef struct packed {
    logic       valid;
    logic       is_verdict;
    logic [7:0] payload_byte;
    logic       frame_good;
  } result_t;

  // XMODEM CRC16 over one byte, MSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/crcdf_in_if.sv @@
`timescale 1ns / 1ps

interface crcdf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

@@ hdl/crcdf_out_if.sv @@
`timescale 1ns / 1ps

interface crcdf_out_if;
  logic       valid;
  logic       ready;
  logic       is_verdict;
  logic [7:0] payload_byte;
  logic       frame_good;

  modport source (output valid, output is_verdict, output payload_byte,
                  output frame_good, input ready);
  modport sink (input valid, input is_verdict, input payload_byte,
                input frame_good, output ready);
endinterface

@@ hdl/crcdf_parser.sv @@
`timescale 1ns / 1ps
`include "crc16_packet_deframer_macros.svh"

module crcdf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  crcdf_pkg::step_t  item,
  output crcdf_pkg::result_t res
);
  import crcdf_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] expected_length, expected_length_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [15:0] crc_byte;
  logic [15:0] count_inc;
  logic [15:0] len_lo;

  assign crc_byte  = crc_update(running_crc, item.rx_byte);
  assign count_inc = bytes_received + 16'd1;
  assign len_lo    = {expected_length[15:8], item.rx_byte};

  // Next state
  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    bytes_received_next  = bytes_received;
    running_crc_next     = running_crc;
    received_crc_next    = received_crc;
    if (item.command) begin
      phase_next           = PH_IDLE;
      expected_length_next = 16'h0000;
      bytes_received_next  = 16'h0000;
      running_crc_next     = 16'h0000;
      received_crc_next    = 16'h0000;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (item.rx_byte inside {START_SHORT, START_LONG}) begin
            phase_next           = (item.rx_byte == START_SHORT) ? PH_LEN_SHORT : PH_LEN_HI;
            expected_length_next = 16'h0000;
            bytes_received_next  = 16'h0000;
            running_crc_next     = 16'h0000;
            received_crc_next    = 16'h0000;
          end
        end
        PH_LEN_SHORT: begin
          expected_length_next = {8'h00, item.rx_byte};
          phase_next = (item.rx_byte == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
        end
        PH_LEN_HI: begin
          expected_length_next = {item.rx_byte, 8'h00};
          phase_next           = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          expected_length_next = len_lo;
          phase_next = (len_lo == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_crc_next    = crc_byte;
          bytes_received_next = count_inc;
          if (count_inc >= expected_length) begin
            phase_next = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          received_crc_next = {item.rx_byte, 8'h00};
          phase_next        = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc_next = {received_crc[15:8], item.rx_byte};
          phase_next        = PH_STOP;
        end
        PH_STOP: begin
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    res = '0;
    if (step && !item.command) begin
      case (phase)
        PH_PAYLOAD: begin
          res.valid        = 1'b1;
          res.payload_byte = item.rx_byte;
        end
        PH_STOP: begin
          res.valid      = 1'b1;
          res.is_verdict = 1'b1;
          res.frame_good = (item.rx_byte == STOP_MARK) && (running_crc == received_crc);
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      expected_length <= 16'h0000;
      bytes_received  <= 16'h0000;
      running_crc     <= 16'h0000;
      received_crc    <= 16'h0000;
    end else if (step) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      bytes_received  <= bytes_received_next;
      running_crc     <= running_crc_next;
      received_crc    <= received_crc_next;
    end
  end

  `CRCDF_ASSERT_NXT(a_cmd_to_idle, step && item.command, phase == PH_IDLE)
  `CRCDF_ASSERT_IMP(a_payload_count, phase == PH_PAYLOAD, bytes_received < expected_length)
  `CRCDF_ASSERT_IMP(a_verdict_at_stop, res.valid && res.is_verdict, phase == PH_STOP)
  `CRCDF_ASSERT_IMP(a_payload_gives_item, step && !item.command && phase == PH_PAYLOAD,
                    res.valid && !res.is_verdict)

endmodule

@@ hdl/crc16_packet_deframer.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Fields                                  | Meaning
// bytes    | in  | command[0], rx_byte[7:0]                | received byte or reset command
// results  | out | is_verdict[0], payload_byte[7:0],       | payload byte or end-of-frame
//          |     | frame_good[0]                           | verdict
//
// One item per cycle sustained while results is not stalled: the per-byte CRC
// update and parser step are combinational logic between the input register and
// the result register. An accepted byte is held in the input register, and its
// result is loaded into the result register as it advances, to be taken there.
// Reset (rst, synchronous) empties both registers and returns the parser to idle.
// A stall on results holds the result register and the input register; bytes
// keeps taking items as long as the input register can drain.

module crc16_packet_deframer (
  input logic   clk,
  input logic   rst,
  crcdf_in_if.sink    bytes,
  crcdf_out_if.source results
);
  import crcdf_pkg::*;

  // Input register
  logic    s1_valid;
  step_t   s1_item;
  logic    s1_adv;

  // Result register
  logic    o_valid;
  result_t o_res;

  result_t step_res;

  // Advance the held item whenever the result register is free or draining.
  assign s1_adv      = s1_valid && (!o_valid || results.ready);
  assign bytes.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  // Capture the payload on accept only.
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_item.command <= bytes.command;
      s1_item.rx_byte <= bytes.rx_byte;
    end
  end

  // Parser state advances once per held item, as it moves to the result side.
  crcdf_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .item (s1_item),
    .res  (step_res)
  );

  // Load a result when the item advances; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= step_res.valid;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_res <= step_res;
    end
  end

  assign results.valid        = o_valid;
  assign results.is_verdict   = o_res.is_verdict;
  assign results.payload_byte = o_res.payload_byte;
  assign results.frame_good   = o_res.frame_good;

endmodule

@@ bench/tb_crc16_packet_deframer.sv @@
`timescale 1ns / 1ps

module tb_crc16_packet_deframer;
  import crcdf_pkg::*;

  // Command codes on the bytes channel.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Random items to queue after the directed part.
  localparam int RANDOM_ITEMS = 1650;
  // Below this many queued items, stop all idling so the run ends at full rate.
  localparam int TAIL_ITEMS   = 150;
  // Cycles to keep watching once nothing is pending.
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_STOP} flaw_t;

  // One item on the results channel, as the deframer should produce it.
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    logic       frame_good;
  } deframed_t;

  logic clk;
  logic rst;

  crcdf_in_if  bytes_if ();
  crcdf_out_if results_if ();

  crc16_packet_deframer u_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if.sink),
    .results (results_if.source)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Items waiting to go into the deframer; the front one is on the bus while valid is high.
  step_t     tx_bytes[$];
  // Payload bytes and verdicts the deframer owes us, oldest first.
  deframed_t due_results[$];

  // Shadow parser state, tracked on every accepted item.
  phase_t      sh_phase;
  logic [15:0] sh_len_want;
  logic [15:0] sh_len_got;
  logic [15:0] sh_crc_calc;
  logic [15:0] sh_crc_rx;

  int n_errors;
  int n_accepted;
  int n_frames;
  int n_payload_seen;
  int n_verdicts_seen;
  int n_good_seen;

  int src_gap;
  int snk_stall;
  bit src_idling;
  bit snk_idling;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  function automatic bit tail_reached();
    return tx_bytes.size() < TAIL_ITEMS;
  endfunction

  // XMODEM CRC16, one message bit at a time, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Advance the shadow parser by one accepted item and queue whatever result it owes.
  task automatic deframe_step(input step_t it);
    deframed_t r;
    r = '0;
    if (it.command == CMD_RESET) begin
      sh_phase    = PH_IDLE;
      sh_len_want = '0;
      sh_len_got  = '0;
      sh_crc_calc = '0;
      sh_crc_rx   = '0;
      return;
    end
    case (sh_phase)
      PH_IDLE: begin
        // Anything but a start byte is dropped here.
        if (it.rx_byte == START_SHORT || it.rx_byte == START_LONG) begin
          sh_phase    = (it.rx_byte == START_SHORT) ? PH_LEN_SHORT : PH_LEN_HI;
          sh_len_want = '0;
          sh_len_got  = '0;
          sh_crc_calc = '0;
          sh_crc_rx   = '0;
        end
      end
      PH_LEN_SHORT: begin
        sh_len_want = {8'h00, it.rx_byte};
        // An empty payload skips straight to the CRC.
        sh_phase = (sh_len_want == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_LEN_HI: begin
        sh_len_want = {it.rx_byte, 8'h00};
        sh_phase    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sh_len_want[7:0] = it.rx_byte;
        sh_phase = (sh_len_want == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sh_crc_calc = crc_byte(sh_crc_calc, it.rx_byte);
        sh_len_got  = sh_len_got + 16'd1;
        if (sh_len_got >= sh_len_want) begin
          sh_phase = PH_CRC_HI;
        end
        r.payload_byte = it.rx_byte;
        due_results = {due_results, r};
      end
      PH_CRC_HI: begin
        sh_crc_rx = {it.rx_byte, 8'h00};
        sh_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        sh_crc_rx[7:0] = it.rx_byte;
        sh_phase = PH_STOP;
      end
      default: begin
        r.is_verdict = 1'b1;
        r.frame_good = (it.rx_byte == STOP_MARK) && (sh_crc_calc == sh_crc_rx);
        sh_phase = PH_IDLE;
        due_results = {due_results, r};
      end
    endcase
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] b);
    step_t it;
    it.command = cmd;
    it.rx_byte = b;
    tx_bytes = {tx_bytes, it};
  endtask

  // Queue a whole frame with random payload; optionally spoil the CRC or the stop byte.
  task automatic add_frame(input bit long_form, input int len, input flaw_t flaw);
    logic [15:0] lv;
    logic [15:0] c;
    logic [7:0]  b;
    lv = 16'(len);
    c  = 16'h0000;
    if (long_form) begin
      push_item(CMD_BYTE, START_LONG);
      push_item(CMD_BYTE, lv[15:8]);
      push_item(CMD_BYTE, lv[7:0]);
    end else begin
      push_item(CMD_BYTE, START_SHORT);
      push_item(CMD_BYTE, lv[7:0]);
    end
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom_range(0, 255));
      c = crc_byte(c, b);
      push_item(CMD_BYTE, b);
    end
    if (flaw == FLAW_CRC) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    push_item(CMD_BYTE, c[15:8]);
    push_item(CMD_BYTE, c[7:0]);
    b = STOP_MARK;
    if (flaw == FLAW_STOP) begin
      while (b == STOP_MARK) begin
        b = 8'($urandom_range(0, 255));
      end
    end
    push_item(CMD_BYTE, b);
    n_frames++;
  endtask

  // Driver: present the front of tx_bytes, hold it until taken, and insert
  // random gaps while the source is in an idling stretch.
  always @(posedge clk) begin
    if (rst) begin
      bytes_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        deframe_step(tx_bytes.pop_front());
        n_accepted++;
      end
      if ($urandom_range(0, 47) == 0) begin
        src_idling = !src_idling;
      end
      // Hold the item on the bus while it is being refused.
      if (!(bytes_if.valid && !bytes_if.ready)) begin
        if (src_gap == 0 && src_idling && !tail_reached() && $urandom_range(0, 4) == 0) begin
          src_gap = $urandom_range(1, 3);
        end
        if (src_gap > 0) begin
          src_gap--;
          bytes_if.valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          bytes_if.valid   <= 1'b1;
          bytes_if.command <= tx_bytes[0].command;
          bytes_if.rx_byte <= tx_bytes[0].rx_byte;
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result taken against the oldest one due, and
  // stall ready in random bursts.
  always @(posedge clk) begin
    deframed_t want;
    if (rst) begin
      results_if.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: verdict %0b byte %02h good %0b",
                                    results_if.is_verdict, results_if.payload_byte,
                                    results_if.frame_good));
        end else begin
          want = due_results.pop_front();
          if (results_if.is_verdict !== want.is_verdict) begin
            report_mismatch($sformatf("is_verdict %0b, want %0b",
                                      results_if.is_verdict, want.is_verdict));
          end
          if (results_if.payload_byte !== want.payload_byte) begin
            report_mismatch($sformatf("payload_byte %02h, want %02h",
                                      results_if.payload_byte, want.payload_byte));
          end
          if (results_if.frame_good !== want.frame_good) begin
            report_mismatch($sformatf("frame_good %0b, want %0b (verdict %0b)",
                                      results_if.frame_good, want.frame_good,
                                      want.is_verdict));
          end
          if (want.is_verdict) begin
            n_verdicts_seen++;
            if (want.frame_good) begin
              n_good_seen++;
            end
          end else begin
            n_payload_seen++;
          end
        end
      end
      if ($urandom_range(0, 47) == 0) begin
        snk_idling = !snk_idling;
      end
      if (snk_stall > 0) begin
        snk_stall--;
        results_if.ready <= 1'b0;
      end else if (snk_idling && !tail_reached() && $urandom_range(0, 4) == 0) begin
        snk_stall = $urandom_range(0, 2);
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the deframer hangs.
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int    n_directed;
    int    pick;
    int    len;
    int    roll;
    int    declared;
    bit    long_form;
    flaw_t flaw;

    rst              = 1'b1;
    bytes_if.valid   = 1'b0;
    bytes_if.command = CMD_BYTE;
    bytes_if.rx_byte = 8'h00;
    results_if.ready = 1'b0;
    n_errors         = 0;
    n_accepted       = 0;
    n_frames         = 0;
    n_payload_seen   = 0;
    n_verdicts_seen  = 0;
    n_good_seen      = 0;
    src_idling       = 1'b1;
    snk_idling       = 1'b1;
    sh_phase         = PH_IDLE;
    sh_len_want      = '0;
    sh_len_got       = '0;
    sh_crc_calc      = '0;
    sh_crc_rx        = '0;

    // Directed: stray bytes at both extremes in idle, an empty short frame,
    // an empty long frame with a bad stop, a one-byte frame with a bad CRC,
    // a frame cut off by the reset command, and a reset command in idle.
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    add_frame(1'b0, 0, FLAW_NONE);
    add_frame(1'b1, 0, FLAW_STOP);
    add_frame(1'b0, 1, FLAW_CRC);
    push_item(CMD_BYTE, START_SHORT);
    push_item(CMD_BYTE, 8'h05);
    push_item(CMD_BYTE, 8'hA5);
    push_item(CMD_RESET, 8'hFF);
    push_item(CMD_RESET, 8'h00);
    n_directed = tx_bytes.size();

    // Random: mostly complete frames with random content, some with a spoiled CRC or
    // stop byte, the rest broken frames abandoned by a reset command and noise between frames.
    while (tx_bytes.size() < n_directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        long_form = 1'($urandom_range(0, 1));
        len = $urandom_range(0, 12);
        // Now and then stretch to the largest short length, or past one byte of length.
        if ($urandom_range(0, 79) == 0) begin
          len = long_form ? $urandom_range(256, 320) : 255;
        end
        roll = $urandom_range(0, 9);
        flaw = (roll < 7) ? FLAW_NONE : ((roll < 9) ? FLAW_CRC : FLAW_STOP);
        add_frame(long_form, len, flaw);
      end else if (pick < 86) begin
        // Declare any length, send a few bytes, then abandon the frame.
        long_form = 1'($urandom_range(0, 1));
        declared  = long_form ? $urandom_range(0, 65535) : $urandom_range(0, 255);
        if (long_form) begin
          push_item(CMD_BYTE, START_LONG);
          push_item(CMD_BYTE, declared[15:8]);
          push_item(CMD_BYTE, declared[7:0]);
        end else begin
          push_item(CMD_BYTE, START_SHORT);
          push_item(CMD_BYTE, declared[7:0]);
        end
        repeat ($urandom_range(0, 6)) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        push_item(CMD_RESET, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        // Resync about half the time; otherwise let the next frame land misaligned.
        if ($urandom_range(0, 1) == 1) begin
          push_item(CMD_RESET, 8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last item to go in and every owed result to come out.
    while (tx_bytes.size() != 0 || due_results.size() != 0) begin
      @(posedge clk);
    end
    // Watch a little longer for anything extra.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items in %0d built frames plus noise and aborted frames",
             n_accepted, n_frames);
    $display("checked %0d payload bytes and %0d verdicts (%0d good), %0d mismatches",
             n_payload_seen, n_verdicts_seen, n_good_seen, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ crc16_packet_deframer.f @@
+incdir+hdl
hdl/crcdf_pkg.sv
hdl/crcdf_in_if.sv
hdl/crcdf_out_if.sv
hdl/crcdf_parser.sv
hdl/crc16_packet_deframer.sv
bench/tb_crc16_packet_deframer.sv
